// ----- sv/fpsis_pkg.sv -----
// fpsis_pkg: shared types and constants of the flow packet size and
// inter-arrival statistics unit; depends on nothing
package fpsis_pkg;

	localparam int LEN_BITS    = 16;
	localparam int SQ_W        = 2 * LEN_BITS;
	localparam int TIME_W      = 52;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 144;

	localparam logic [TIME_W-1:0] USEC_PER_SEC = TIME_W'(1000000);

	// one queued request, classified and ready for the back end
	typedef struct packed {
		logic                upload;
		logic [LEN_BITS-1:0] len;
		logic [SQ_W-1:0]     len_sq;
		logic [TIME_W-1:0]   now;
	} qent_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] rem_init;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] root;
	} sqrt_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_UPD,
		S_GAP,
		S_ISS,
		S_MEAN_GO,
		S_MEAN_WT,
		S_VAR_GO,
		S_VAR_WT,
		S_SDEV_MUL,
		S_SDEV_GO,
		S_SDEV_WT,
		S_AVG_GO,
		S_AVG_WT,
		S_ISQ_GO,
		S_ISQ_WT,
		S_IDEV_MUL,
		S_IDEV_GO,
		S_IDEV_WT,
		S_OUT
	} back_state_t;

endpackage

// ----- sv/fpsis_div.sv -----
// fpsis_div: iterative restoring divider, two quotient bits per cycle
// depends on fpsis_pkg
module fpsis_div (
	input  logic                clk,
	input  logic                arst_n,
	input  fpsis_pkg::div_req_t req,
	output fpsis_pkg::div_rsp_t rsp
);

	localparam int STEPS = 32;
	localparam int CNT_W = $clog2(STEPS);

	logic [63:0]      dvd_q;
	logic [31:0]      rem_q;
	logic [31:0]      dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [63:0]      dvd_nxt;
	logic [31:0]      rem_nxt;

	// two restoring steps
	always_comb begin
		logic [32:0] t;
		dvd_nxt = dvd_q;
		rem_nxt = rem_q;
		for (int i = 0; i < 2; i++) begin
			t = {rem_nxt, dvd_nxt[63]};
			if (t >= {1'b0, dsr_q}) begin
				rem_nxt = 32'(t - {1'b0, dsr_q});
				dvd_nxt = {dvd_nxt[62:0], 1'b1};
			end else begin
				rem_nxt = t[31:0];
				dvd_nxt = {dvd_nxt[62:0], 1'b0};
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= req.rem_init;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ----- sv/fpsis_sqrt.sv -----
// fpsis_sqrt: digit-by-digit floor square root of a 64-bit value,
// two root bits per cycle; depends on fpsis_pkg
module fpsis_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fpsis_pkg::sqrt_req_t req,
	output fpsis_pkg::sqrt_rsp_t rsp
);

	localparam int STEPS = 16;
	localparam int CNT_W = $clog2(STEPS);

	logic [63:0]      rad_q;
	logic [34:0]      rem_q;
	logic [31:0]      root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [63:0]      rad_nxt;
	logic [34:0]      rem_nxt;
	logic [31:0]      root_nxt;

	// two root digits
	always_comb begin
		logic [34:0] r;
		logic [34:0] trial;
		rad_nxt  = rad_q;
		rem_nxt  = rem_q;
		root_nxt = root_q;
		for (int i = 0; i < 2; i++) begin
			r     = {rem_nxt[32:0], rad_nxt[63:62]};
			trial = {1'b0, root_nxt, 2'b01};
			rad_nxt = {rad_nxt[61:0], 2'b00};
			if (r >= trial) begin
				rem_nxt  = r - trial;
				root_nxt = {root_nxt[30:0], 1'b1};
			end else begin
				rem_nxt  = r;
				root_nxt = {root_nxt[30:0], 1'b0};
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_nxt;
			rem_q  <= rem_nxt;
			root_q <= root_nxt;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

// ----- sv/fpsis_front.sv -----
// fpsis_front: accepts requests, forms arrival time and squared length,
// and holds them in a two-entry queue; depends on fpsis_pkg
module fpsis_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// pkt_length[15:0], ts_sec[47:16], ts_usec[67:48], zero pad
	input  logic [fpsis_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// upload[0]
	input  logic [0:0]                             s_axis_tuser,
	input  logic                                   pop,
	output fpsis_pkg::qent_t                       head,
	output logic                                   head_valid
);

	fpsis_pkg::qent_t ent_q [2];
	fpsis_pkg::qent_t ent_new;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign head_valid    = (cnt_q != 2'd0);
	assign head          = ent_q[rd_ptr_q];

	// classify the incoming request
	always_comb begin
		logic [fpsis_pkg::LEN_BITS-1:0] len;
		len             = s_axis_tdata[fpsis_pkg::LEN_BITS-1:0];
		ent_new.upload  = s_axis_tuser[0];
		ent_new.len     = len;
		ent_new.len_sq  = fpsis_pkg::SQ_W'(len) * fpsis_pkg::SQ_W'(len);
		ent_new.now     = fpsis_pkg::TIME_W'(s_axis_tdata[47:16]) * fpsis_pkg::USEC_PER_SEC
			+ fpsis_pkg::TIME_W'(s_axis_tdata[67:48]);
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= ent_new;
		end
	end

endmodule

// ----- sv/fpsis_back.sv -----
// fpsis_back: per-direction accumulators, statistics sequencer and
// output register; depends on fpsis_pkg, fpsis_div, fpsis_sqrt
module fpsis_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fpsis_pkg::qent_t                    head,
	input  logic                                head_valid,
	output logic                                pop,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [fpsis_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic [0:0]                          m_axis_tuser
);

	localparam logic [31:0] MAX32 = '1;

	fpsis_pkg::back_state_t state_q, state_nxt;
	fpsis_pkg::div_req_t    div_req;
	fpsis_pkg::div_rsp_t    div_rsp;
	fpsis_pkg::sqrt_req_t   sqrt_req;
	fpsis_pkg::sqrt_rsp_t   sqrt_rsp;

	// per-direction state
	logic [31:0]                  pkt_cnt_q  [2];
	logic [47:0]                  byte_sum_q [2];
	logic [63:0]                  size_sq_q  [2];
	logic [63:0]                  iat_sq_q   [2];
	logic [fpsis_pkg::TIME_W-1:0] first_q    [2];
	logic [fpsis_pkg::TIME_W-1:0] last_q     [2];

	// working registers
	fpsis_pkg::qent_t             ent_q;
	logic [31:0]                  n_q;
	logic [fpsis_pkg::TIME_W-1:0] gap_q;
	logic [63:0]                  sq_q;
	logic [55:0]                  mean_q;
	logic [63:0]                  v_q;
	logic [63:0]                  m2_q;
	logic [23:0]                  dev_size_q;
	logic [51:0]                  avg_full_q;
	logic [31:0]                  dev_iat_q;

	logic                         dir;
	logic [31:0]                  n_nxt;
	logic [48:0]                  bs_sum;
	logic [64:0]                  ssq_sum;
	logic [64:0]                  iss_sum;
	logic                         var_sat;
	logic                         sdev_skip;
	logic                         idev_skip;
	logic                         n_lt2;
	logic                         n_lt3;
	logic                         time_back;
	logic                         load;

	assign dir = ent_q.upload;

	fpsis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fpsis_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	// update values and skip conditions
	always_comb begin
		n_nxt     = (pkt_cnt_q[dir] == MAX32) ? MAX32 : pkt_cnt_q[dir] + 32'd1;
		bs_sum    = {1'b0, byte_sum_q[dir]} + 49'(ent_q.len);
		ssq_sum   = {1'b0, size_sq_q[dir]} + 65'(ent_q.len_sq);
		iss_sum   = {1'b0, iat_sq_q[dir]} + {1'b0, sq_q};
		var_sat   = {16'b0, size_sq_q[dir][63:48]} >= n_q;
		sdev_skip = (mean_q[55:32] != 24'd0) || (m2_q >= v_q);
		idev_skip = (avg_full_q[51:32] != 20'd0) || (m2_q >= v_q);
		n_lt2     = n_q < 32'd2;
		n_lt3     = n_q < 32'd3;
		time_back = last_q[dir] < first_q[dir];
		load      = (state_q == fpsis_pkg::S_OUT) && (!m_axis_tvalid || m_axis_tready);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpsis_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and unit requests
	always_comb begin
		state_nxt = state_q;
		div_req   = '0;
		sqrt_req  = '0;
		pop       = 1'b0;
		case (state_q)
			fpsis_pkg::S_IDLE: begin
				if (head_valid) begin
					pop       = 1'b1;
					state_nxt = fpsis_pkg::S_UPD;
				end
			end
			fpsis_pkg::S_UPD: begin
				state_nxt = (n_nxt == 32'd1) ? fpsis_pkg::S_MEAN_GO : fpsis_pkg::S_GAP;
			end
			fpsis_pkg::S_GAP: state_nxt = fpsis_pkg::S_ISS;
			fpsis_pkg::S_ISS: state_nxt = fpsis_pkg::S_MEAN_GO;
			fpsis_pkg::S_MEAN_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {8'b0, byte_sum_q[dir], 8'b0};
				div_req.rem_init = '0;
				div_req.divisor  = n_q;
				state_nxt        = fpsis_pkg::S_MEAN_WT;
			end
			fpsis_pkg::S_MEAN_WT: begin
				if (div_rsp.done) begin
					state_nxt = fpsis_pkg::S_VAR_GO;
				end
			end
			fpsis_pkg::S_VAR_GO: begin
				if (var_sat) begin
					state_nxt = fpsis_pkg::S_SDEV_MUL;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = {size_sq_q[dir][47:0], 16'b0};
					div_req.rem_init = {16'b0, size_sq_q[dir][63:48]};
					div_req.divisor  = n_q;
					state_nxt        = fpsis_pkg::S_VAR_WT;
				end
			end
			fpsis_pkg::S_VAR_WT: begin
				if (div_rsp.done) begin
					state_nxt = fpsis_pkg::S_SDEV_MUL;
				end
			end
			fpsis_pkg::S_SDEV_MUL: state_nxt = fpsis_pkg::S_SDEV_GO;
			fpsis_pkg::S_SDEV_GO: begin
				if (sdev_skip) begin
					state_nxt = fpsis_pkg::S_AVG_GO;
				end else begin
					sqrt_req.start    = 1'b1;
					sqrt_req.radicand = v_q - m2_q;
					state_nxt         = fpsis_pkg::S_SDEV_WT;
				end
			end
			fpsis_pkg::S_SDEV_WT: begin
				if (sqrt_rsp.done) begin
					state_nxt = fpsis_pkg::S_AVG_GO;
				end
			end
			fpsis_pkg::S_AVG_GO: begin
				if (n_lt2) begin
					state_nxt = fpsis_pkg::S_OUT;
				end else if (time_back) begin
					state_nxt = fpsis_pkg::S_ISQ_GO;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = 64'(last_q[dir] - first_q[dir]);
					div_req.rem_init = '0;
					div_req.divisor  = n_q - 32'd1;
					state_nxt        = fpsis_pkg::S_AVG_WT;
				end
			end
			fpsis_pkg::S_AVG_WT: begin
				if (div_rsp.done) begin
					state_nxt = fpsis_pkg::S_ISQ_GO;
				end
			end
			fpsis_pkg::S_ISQ_GO: begin
				if (n_lt3) begin
					state_nxt = fpsis_pkg::S_OUT;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = iat_sq_q[dir];
					div_req.rem_init = '0;
					div_req.divisor  = n_q - 32'd1;
					state_nxt        = fpsis_pkg::S_ISQ_WT;
				end
			end
			fpsis_pkg::S_ISQ_WT: begin
				if (div_rsp.done) begin
					state_nxt = fpsis_pkg::S_IDEV_MUL;
				end
			end
			fpsis_pkg::S_IDEV_MUL: state_nxt = fpsis_pkg::S_IDEV_GO;
			fpsis_pkg::S_IDEV_GO: begin
				if (idev_skip) begin
					state_nxt = fpsis_pkg::S_OUT;
				end else begin
					sqrt_req.start    = 1'b1;
					sqrt_req.radicand = v_q - m2_q;
					state_nxt         = fpsis_pkg::S_IDEV_WT;
				end
			end
			fpsis_pkg::S_IDEV_WT: begin
				if (sqrt_rsp.done) begin
					state_nxt = fpsis_pkg::S_OUT;
				end
			end
			fpsis_pkg::S_OUT: begin
				if (load) begin
					state_nxt = fpsis_pkg::S_IDLE;
				end
			end
			default: state_nxt = fpsis_pkg::S_IDLE;
		endcase
	end

	// accumulators that reset clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				pkt_cnt_q[i]  <= '0;
				byte_sum_q[i] <= '0;
				size_sq_q[i]  <= '0;
				iat_sq_q[i]   <= '0;
			end
		end else begin
			if (state_q == fpsis_pkg::S_UPD) begin
				pkt_cnt_q[dir]  <= n_nxt;
				byte_sum_q[dir] <= bs_sum[48] ? '1 : bs_sum[47:0];
				size_sq_q[dir]  <= ssq_sum[64] ? '1 : ssq_sum[63:0];
			end
			if (state_q == fpsis_pkg::S_ISS) begin
				iat_sq_q[dir] <= iss_sum[64] ? '1 : iss_sum[63:0];
			end
		end
	end

	// arrival times and working values
	always_ff @(posedge clk) begin
		case (state_q)
			fpsis_pkg::S_IDLE: begin
				if (head_valid) begin
					ent_q <= head;
				end
			end
			fpsis_pkg::S_UPD: begin
				n_q         <= n_nxt;
				gap_q       <= (ent_q.now >= last_q[dir]) ? ent_q.now - last_q[dir]
					: last_q[dir] - ent_q.now;
				last_q[dir] <= ent_q.now;
				if (n_nxt == 32'd1) begin
					first_q[dir] <= ent_q.now;
				end
			end
			fpsis_pkg::S_GAP: begin
				sq_q <= (gap_q[51:32] != 20'd0) ? '1
					: {32'b0, gap_q[31:0]} * {32'b0, gap_q[31:0]};
			end
			fpsis_pkg::S_MEAN_WT: begin
				if (div_rsp.done) begin
					mean_q <= div_rsp.quotient[55:0];
				end
			end
			fpsis_pkg::S_VAR_GO: begin
				if (var_sat) begin
					v_q <= '1;
				end
			end
			fpsis_pkg::S_VAR_WT, fpsis_pkg::S_ISQ_WT: begin
				if (div_rsp.done) begin
					v_q <= div_rsp.quotient;
				end
			end
			fpsis_pkg::S_SDEV_MUL: begin
				m2_q <= {32'b0, mean_q[31:0]} * {32'b0, mean_q[31:0]};
			end
			fpsis_pkg::S_SDEV_GO: begin
				if (sdev_skip) begin
					dev_size_q <= '0;
				end
			end
			fpsis_pkg::S_SDEV_WT: begin
				if (sqrt_rsp.done) begin
					dev_size_q <= (sqrt_rsp.root[31:24] != 8'd0) ? '1 : sqrt_rsp.root[23:0];
				end
			end
			fpsis_pkg::S_AVG_GO: begin
				if (n_lt2) begin
					avg_full_q <= '0;
					dev_iat_q  <= '0;
				end else if (time_back) begin
					avg_full_q <= '0;
				end
			end
			fpsis_pkg::S_AVG_WT: begin
				if (div_rsp.done) begin
					avg_full_q <= div_rsp.quotient[51:0];
				end
			end
			fpsis_pkg::S_ISQ_GO: begin
				if (n_lt3) begin
					dev_iat_q <= '0;
				end
			end
			fpsis_pkg::S_IDEV_MUL: begin
				m2_q <= {32'b0, avg_full_q[31:0]} * {32'b0, avg_full_q[31:0]};
			end
			fpsis_pkg::S_IDEV_GO: begin
				if (idev_skip) begin
					dev_iat_q <= '0;
				end
			end
			fpsis_pkg::S_IDEV_WT: begin
				if (sqrt_rsp.done) begin
					dev_iat_q <= sqrt_rsp.root;
				end
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			m_axis_tuser[0]       <= dir;
			m_axis_tdata[31:0]    <= n_q;
			m_axis_tdata[55:32]   <= (mean_q[55:24] != 32'd0) ? '1 : mean_q[23:0];
			m_axis_tdata[79:56]   <= dev_size_q;
			m_axis_tdata[111:80]  <= (avg_full_q[51:32] != 20'd0) ? '1 : avg_full_q[31:0];
			m_axis_tdata[143:112] <= dev_iat_q;
		end
	end

	// a unit is only started when idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_sqrt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_req.start |-> !sqrt_rsp.busy)
		else $error("square root started while busy");

	// a loaded result is presented next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_axis_tvalid)
		else $error("loaded result not presented");

	// iat deviation only from the third packet on
	a_dev_iat_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[143:112] != 32'd0)) |-> (m_axis_tdata[31:0] > 32'd2))
		else $error("iat deviation below three packets");

endmodule

// ----- sv/flow_packet_size_iat_statistics_unit.sv -----
// flow_packet_size_iat_statistics_unit: top level of the per-direction packet
// size and inter-arrival statistics block; depends on fpsis_pkg, fpsis_front, fpsis_back
//
// channel   dir  bus          contents
// s_axis    in   tdata 72b    packet length, timestamp seconds, microseconds
//                tuser 1b     upload flag
// m_axis    out  tdata 144b   count, mean size, size deviation, mean iat, iat deviation
//                tuser 1b     direction
//
// one request holds the back end while it runs its divisions on the shared radix-4
// divider and its square roots; a first packet runs two divisions and no root,
// later ones up to four divisions and two roots, plus pop, update, gap, multiply
// and output steps; early exits shorten it.
// reset clears the counters and sums at once; arrival times are written before use.
// a two-entry queue decouples intake from the sequencer; a full output register
// holds the sequencer until the result is taken.
module flow_packet_size_iat_statistics_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// pkt_length[15:0], ts_sec[47:16], ts_usec[67:48], zero pad
	input  logic [fpsis_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// upload[0]
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// packet_count[31:0], avg_size_q8[55:32], dev_size_q8[79:56],
	// avg_iat_us[111:80], dev_iat_us[143:112]
	output logic [fpsis_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// direction[0]
	output logic [0:0]                          m_axis_tuser
);

	fpsis_pkg::qent_t head;
	logic             head_valid;
	logic             pop;

	fpsis_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.pop           (pop),
		.head          (head),
		.head_valid    (head_valid)
	);

	fpsis_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
